[hdl/fjat_pkg.sv]
package fjat_pkg;

	localparam int INT_BITS = 31;
	localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	localparam logic [3:0] TK_KEYCHAR  = 4'd0;
	localparam logic [3:0] TK_KEYEND   = 4'd1;
	localparam logic [3:0] TK_STRCHAR  = 4'd2;
	localparam logic [3:0] TK_STREND   = 4'd3;
	localparam logic [3:0] TK_INT      = 4'd4;
	localparam logic [3:0] TK_OBJSTART = 4'd5;
	localparam logic [3:0] TK_OBJEND   = 4'd6;
	localparam logic [3:0] TK_ARRAYEND = 4'd7;
	localparam logic [3:0] TK_ERROR    = 4'd8;

	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	typedef enum logic [8:0] {
		PH_START = 9'b000000001,
		PH_ARRAY = 9'b000000010,
		PH_OBJ   = 9'b000000100,
		PH_KEY   = 9'b000001000,
		PH_COLON = 9'b000010000,
		PH_VALUE = 9'b000100000,
		PH_STR   = 9'b001000000,
		PH_DONE  = 9'b010000000,
		PH_ERR   = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       text_end;
	} char_t;

	typedef struct packed {
		logic [3:0]          token_kind;
		logic [7:0]          char_out;
		logic [INT_BITS-1:0] int_value;
		logic                int_overflow;
		logic                last_of_run;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} tok_pair_t;

	typedef struct packed {
		logic            room;
		logic [Q_CW-1:0] count;
	} qstat_t;

endpackage

[hdl/fjat_core.sv]
module fjat_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  fjat_pkg::char_t     char_s1,
	output fjat_pkg::tok_pair_t pair
);

	fjat_pkg::phase_t                phase_q, phase_d;
	logic [fjat_pkg::INT_BITS-1:0]   acc_q, acc_d;
	logic                            ovf_q, ovf_d;
	logic                            dig_q, dig_d;

	logic [7:0]                      c;
	logic                            is_ws, is_comma, is_quote, is_rbrace, is_digit;
	logic [3:0]                      dval;
	logic [fjat_pkg::INT_BITS+3:0]   acc_wide;
	logic [fjat_pkg::INT_BITS+3:0]   acc_x10;
	logic                            acc_ovf;

	logic                            obj_emit, obj_move;
	fjat_pkg::token_t                obj_tok;
	fjat_pkg::phase_t                obj_phase;

	fjat_pkg::token_t                t0, t1;
	logic [1:0]                      n;

	function automatic fjat_pkg::token_t mk(
		input logic [3:0]                    kind,
		input logic [7:0]                    ch,
		input logic [fjat_pkg::INT_BITS-1:0] val,
		input logic                          ovf
	);
		fjat_pkg::token_t t;
		t.token_kind   = kind;
		t.char_out     = ch;
		t.int_value    = val;
		t.int_overflow = ovf;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	assign c         = char_s1.char_in;
	assign is_ws     = (c == fjat_pkg::CH_SPACE) || (c == fjat_pkg::CH_NEWLINE);
	assign is_comma  = (c == fjat_pkg::CH_COMMA);
	assign is_quote  = (c == fjat_pkg::CH_QUOTE);
	assign is_rbrace = (c == fjat_pkg::CH_RBRACE);
	assign is_digit  = (c >= fjat_pkg::CH_ZERO) && (c <= fjat_pkg::CH_NINE);
	assign dval      = c[3:0];

	// acc * 10 + digit, overflow when above the maximum
	assign acc_wide = {4'b0000, acc_q};
	assign acc_x10  = (acc_wide << 3) + (acc_wide << 1)
		+ {{fjat_pkg::INT_BITS{1'b0}}, dval};
	assign acc_ovf  = acc_x10 > {4'b0000, fjat_pkg::INT_MAX};

	// handling of a byte between object members
	assign obj_move  = !(is_ws || is_comma);
	assign obj_emit  = obj_move && !is_quote;
	assign obj_tok   = is_rbrace ? mk(fjat_pkg::TK_OBJEND, 8'h00, '0, 1'b0)
		: mk(fjat_pkg::TK_ERROR, c, '0, 1'b0);
	assign obj_phase = is_quote ? fjat_pkg::PH_KEY
		: (is_rbrace ? fjat_pkg::PH_ARRAY : fjat_pkg::PH_ERR);

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		dig_d   = dig_q;
		t0      = '0;
		t1      = '0;
		n       = 2'd0;
		case (phase_q)
			fjat_pkg::PH_START: begin
				if (c == fjat_pkg::CH_LBRACKET) begin
					phase_d = fjat_pkg::PH_ARRAY;
				end else if (!is_ws) begin
					t0      = mk(fjat_pkg::TK_ERROR, c, '0, 1'b0);
					n       = 2'd1;
					phase_d = fjat_pkg::PH_ERR;
				end
			end
			fjat_pkg::PH_ARRAY: begin
				if (c == fjat_pkg::CH_LBRACE) begin
					t0      = mk(fjat_pkg::TK_OBJSTART, 8'h00, '0, 1'b0);
					n       = 2'd1;
					phase_d = fjat_pkg::PH_OBJ;
				end else if (c == fjat_pkg::CH_RBRACKET) begin
					t0      = mk(fjat_pkg::TK_ARRAYEND, 8'h00, '0, 1'b0);
					n       = 2'd1;
					phase_d = fjat_pkg::PH_DONE;
				end else if (!is_ws && !is_comma) begin
					t0      = mk(fjat_pkg::TK_ERROR, c, '0, 1'b0);
					n       = 2'd1;
					phase_d = fjat_pkg::PH_ERR;
				end
			end
			fjat_pkg::PH_OBJ: begin
				if (obj_emit) begin
					t0 = obj_tok;
					n  = 2'd1;
				end
				if (obj_move) begin
					phase_d = obj_phase;
				end
			end
			fjat_pkg::PH_KEY: begin
				n = 2'd1;
				if (is_quote) begin
					t0      = mk(fjat_pkg::TK_KEYEND, 8'h00, '0, 1'b0);
					phase_d = fjat_pkg::PH_COLON;
				end else begin
					t0 = mk(fjat_pkg::TK_KEYCHAR, c, '0, 1'b0);
				end
			end
			fjat_pkg::PH_COLON: begin
				if (c == fjat_pkg::CH_COLON) begin
					phase_d = fjat_pkg::PH_VALUE;
					dig_d   = 1'b0;
					acc_d   = '0;
					ovf_d   = 1'b0;
				end else begin
					t0      = mk(fjat_pkg::TK_ERROR, c, '0, 1'b0);
					n       = 2'd1;
					phase_d = fjat_pkg::PH_ERR;
				end
			end
			fjat_pkg::PH_VALUE: begin
				if (is_digit) begin
					dig_d = 1'b1;
					if (acc_ovf) begin
						acc_d = fjat_pkg::INT_MAX;
						ovf_d = 1'b1;
					end else begin
						acc_d = acc_x10[fjat_pkg::INT_BITS-1:0];
					end
				end else if (dig_q) begin
					t0      = mk(fjat_pkg::TK_INT, 8'h00, acc_q, ovf_q);
					n       = 2'd1;
					dig_d   = 1'b0;
					acc_d   = '0;
					ovf_d   = 1'b0;
					phase_d = fjat_pkg::PH_OBJ;
					if (obj_move) begin
						phase_d = obj_phase;
					end
					if (obj_emit) begin
						t1 = obj_tok;
						n  = 2'd2;
					end
				end else if (is_quote) begin
					phase_d = fjat_pkg::PH_STR;
				end else if (!is_ws) begin
					t0      = mk(fjat_pkg::TK_ERROR, c, '0, 1'b0);
					n       = 2'd1;
					phase_d = fjat_pkg::PH_ERR;
				end
			end
			fjat_pkg::PH_STR: begin
				n = 2'd1;
				if (is_quote) begin
					t0      = mk(fjat_pkg::TK_STREND, 8'h00, '0, 1'b0);
					phase_d = fjat_pkg::PH_OBJ;
				end else begin
					t0 = mk(fjat_pkg::TK_STRCHAR, c, '0, 1'b0);
				end
			end
			fjat_pkg::PH_DONE: begin
			end
			fjat_pkg::PH_ERR: begin
			end
			default: begin
				phase_d = fjat_pkg::PH_ERR;
			end
		endcase
		if (n == 2'd1) begin
			t0.last_of_run = 1'b1;
		end
		if (n == 2'd2) begin
			t1.last_of_run = 1'b1;
		end
		if (char_s1.text_end) begin
			phase_d = fjat_pkg::PH_START;
			acc_d   = '0;
			ovf_d   = 1'b0;
			dig_d   = 1'b0;
		end
	end

	assign pair.count  = n;
	assign pair.first  = t0;
	assign pair.second = t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fjat_pkg::PH_START;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			dig_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			dig_q   <= dig_d;
		end
	end

endmodule

[hdl/fjat_queue.sv]
module fjat_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fjat_pkg::tok_pair_t pair,
	input  logic                token_stall,
	output logic                token_valid,
	output fjat_pkg::token_t    token_data,
	output fjat_pkg::qstat_t    status
);

	fjat_pkg::token_t               mem_q [fjat_pkg::Q_DEPTH];
	logic [fjat_pkg::Q_AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [fjat_pkg::Q_AW-1:0]      wr_ptr_1;
	logic [fjat_pkg::Q_CW-1:0]      count_q, count_after_pop, push_n;
	logic                           pop;

	assign token_valid     = (count_q != '0);
	assign token_data      = mem_q[rd_ptr_q];
	assign pop             = token_valid && !token_stall;
	assign count_after_pop = count_q - {{(fjat_pkg::Q_CW-1){1'b0}}, pop};
	assign push_n          = push ? fjat_pkg::Q_CW'(pair.count) : '0;
	assign wr_ptr_1        = wr_ptr_q + fjat_pkg::Q_AW'(1);

	assign status.room  = (count_after_pop <= fjat_pkg::Q_CW'(fjat_pkg::Q_DEPTH - 2));
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push && (pair.count != 2'd0)) begin
			mem_q[wr_ptr_q] <= pair.first;
		end
		if (push && (pair.count == 2'd2)) begin
			mem_q[wr_ptr_1] <= pair.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fjat_pkg::Q_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + {{(fjat_pkg::Q_AW-1){1'b0}}, pop};
			count_q  <= count_after_pop + push_n;
		end
	end

endmodule

[hdl/flat_json_array_tokenizer_top.sv]
// tokenizer for a json array of flat objects, one text byte per transaction
// char channel: char_valid, char_stall, char_data (char_in, text_end)
// token channel: token_valid, token_stall, token_data (kind, char, integer,
//   overflow flag, last_of_run on the final token of a byte)
// a byte enters an input register, then one pass of parse logic writes
//   zero, one or two tokens into a four-entry token queue
// path: a byte passes the input register and then the token queue before its first
//   token is offered; it waits in the input register while the queue lacks room
// throughput: one byte per cycle while the queue keeps room for two tokens;
//   the token port delivers one token per cycle while token_stall is low, so a
//   byte that gives two tokens (integer then brace or error) needs two token transfers
// when token_stall holds the queue fills and char_stall rises once fewer
//   than two entries are free; nothing is dropped
// text_end on a byte returns the parser to its start state after that byte
// reset: asynchronous, clears parser state, the input register's valid flag and queue
module flat_json_array_tokenizer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  fjat_pkg::char_t  char_data,
	output logic             token_valid,
	input  logic             token_stall,
	output fjat_pkg::token_t token_data
);

	fjat_pkg::char_t     char_s1;
	logic                valid_s1;
	logic                fire;
	logic                accept;
	fjat_pkg::tok_pair_t pair;
	fjat_pkg::qstat_t    status;

	assign fire       = valid_s1 && status.room;
	assign char_stall = valid_s1 && !status.room;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_data;
		end
	end

	fjat_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.char_s1 (char_s1),
		.pair    (pair)
	);

	fjat_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (fire),
		.pair        (pair),
		.token_stall (token_stall),
		.token_valid (token_valid),
		.token_data  (token_data),
		.status      (status)
	);

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= fjat_pkg::Q_CW'(fjat_pkg::Q_DEPTH))
		else $error("token queue count above depth");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (pair.count != 2'd0)) |=> token_valid)
		else $error("pushed token not offered");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (pair.count == 2'd2)) |->
		(!pair.first.last_of_run && pair.second.last_of_run))
		else $error("last_of_run misplaced on two-token byte");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (pair.count != 2'd3))
		else $error("parser emitted more than two tokens");
`endif

endmodule
